/* rtl/atu_pkg.sv */
// atu_pkg: types, constants and elaboration-time tables for the tilt angle unit
// used by every module of the unit; depends on nothing else
`default_nettype none

package atu_pkg;

  // angle selector codes
  typedef enum logic [1:0] {
    CMD_VS_Z = 2'd0,
    CMD_X    = 2'd1,
    CMD_Y    = 2'd2,
    CMD_ZERO = 2'd3
  } cmd_e;

  localparam int FRAC_SQRT  = 40;               // fractional bits of the roots
  localparam int SQRT_ITERS = 16 + FRAC_SQRT;   // one root bit per cell
  localparam int DIV_STEPS  = 62;               // 2 integer + 60 fraction bits
  localparam int DEG_BITS   = 7;
  localparam logic [DEG_BITS-1:0] DEG_MAX = 7'd90;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        neg;
    logic [15:0] other;
  } sq_meta_t;

  typedef struct packed {
    logic                neg;
    logic                fixed;
    logic [DEG_BITS-1:0] deg_fix;
  } res_meta_t;

  typedef struct packed {
    logic [59:0] rem;
    logic [55:0] root;
    logic [31:0] s;
    sq_meta_t    meta;
  } sq_t;

  typedef struct packed {
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] acc;
    res_meta_t          meta;
  } cord_t;

  typedef struct packed {
    logic [63:0]          r;
    logic [63:0]          bx;
    logic [DIV_STEPS-1:0] q;
    logic signed [63:0]   acc;
    logic                 cy_neg;
    logic                 zero;
    res_meta_t            meta;
  } div_t;

  typedef struct packed {
    logic [39:0]         a36;
    logic [DEG_BITS-1:0] deg;
    res_meta_t           meta;
  } deg_t;

  // shift and subtract quotient, used only while building tables
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      q = q << 1;
      if (r >= b) begin
        r    = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-sh) in Q60 by its alternating series
  function automatic longint unsigned recip_pow2(int sh);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned t;
    int k;
    p   = 64'd1 << (60 - sh);
    sum = p;
    for (k = 1; k < 64; k++) begin
      p = p >> (2 * sh);
      t = udiv64(p, longint'(unsigned'(2 * k + 1)));
      if ((k & 1) != 0) sum = sum - t;
      else              sum = sum + t;
    end
    return sum;
  endfunction

  // atan(1/3) in Q60
  function automatic longint unsigned recip_three();
    longint unsigned p;
    longint unsigned sum;
    longint unsigned t;
    int k;
    p   = (64'd1 << 60) / 64'd3;
    sum = p;
    for (k = 1; k < 64; k++) begin
      p = p / 64'd9;
      t = udiv64(p, longint'(unsigned'(2 * k + 1)));
      if ((k & 1) != 0) sum = sum - t;
      else              sum = sum + t;
    end
    return sum;
  endfunction

  // rotation angle of one cordic stage; the first one is atan(1/2)+atan(1/3)
  function automatic logic [63:0] atan_entry(int i);
    if (i == 0) return recip_pow2(1) + recip_three();
    else        return recip_pow2(i);
  endfunction

  // smallest angle code (Q36 radians) that reaches k degrees
  typedef logic [39:0] thr_tab_t [0:127];

  function automatic thr_tab_t build_thr();
    thr_tab_t        tab;
    longint unsigned num;
    int k;
    for (k = 0; k < 128; k++) begin
      if (k > 90) begin
        tab[k] = '1;
      end else begin
        num    = (longint'(unsigned'(k)) * 64'd314159) << 36;
        tab[k] = 40'((num + 64'd17999999) / 64'd18000000);
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t DEG_THR = build_thr();

endpackage

`default_nettype wire

/* rtl/atu_sqrt_cell.sv */
// atu_sqrt_cell: one restoring square root step, one root bit per cycle
// depends on atu_pkg
`default_nettype none

module atu_sqrt_cell (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  atu_pkg::sq_t   in_data,
  output logic           out_valid,
  output atu_pkg::sq_t   out_data
);
  import atu_pkg::*;

  logic [59:0] rem_t;
  logic [59:0] trial;
  logic        ge;
  sq_t         data_next;

  always_comb begin
    rem_t = {in_data.rem[57:0], in_data.s[31:30]};
    trial = {2'b00, in_data.root, 2'b01};
    ge    = rem_t >= trial;
    data_next      = in_data;
    data_next.s    = {in_data.s[29:0], 2'b00};
    data_next.rem  = ge ? (rem_t - trial) : rem_t;
    data_next.root = {in_data.root[54:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

/* rtl/atu_cordic_cell.sv */
// atu_cordic_cell: one vectoring rotation of the arctangent engine
// depends on atu_pkg (angle table)
`default_nettype none

module atu_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  input  atu_pkg::cord_t  in_data,
  output logic            out_valid,
  output atu_pkg::cord_t  out_data
);
  import atu_pkg::*;

  localparam logic signed [63:0] ANGLE = atan_entry(STAGE);

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  cord_t              data_next;

  always_comb begin
    dx = in_data.cy >>> STAGE;
    dy = in_data.cx >>> STAGE;
    data_next = in_data;
    if (!in_data.cy[63]) begin
      data_next.cx  = in_data.cx + dx;
      data_next.cy  = in_data.cy - dy;
      data_next.acc = in_data.acc + ANGLE;
    end else begin
      data_next.cx  = in_data.cx - dx;
      data_next.cy  = in_data.cy + dy;
      data_next.acc = in_data.acc - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

/* rtl/atu_div_cell.sv */
// atu_div_cell: one restoring division step for the residual angle y/x
// depends on atu_pkg
`default_nettype none

module atu_div_cell #(
  parameter int STEP = 0
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  atu_pkg::div_t  in_data,
  output logic           out_valid,
  output atu_pkg::div_t  out_data
);
  import atu_pkg::*;

  // the two integer steps compare against 2x and x, fraction steps shift first
  localparam bit FRAC  = (STEP >= 2);
  localparam int SCALE = (STEP == 0) ? 1 : 0;

  logic [64:0] rem_t;
  logic [64:0] cmp;
  logic        ge;
  div_t        data_next;

  always_comb begin
    rem_t = FRAC ? {in_data.r, 1'b0} : {1'b0, in_data.r};
    cmp   = {1'b0, in_data.bx} << SCALE;
    ge    = rem_t >= cmp;
    data_next   = in_data;
    data_next.r = ge ? 64'(rem_t - cmp) : 64'(rem_t);
    data_next.q = {in_data.q[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

/* rtl/atu_deg_cell.sv */
// atu_deg_cell: one bisection step turning a Q36 angle into whole degrees
// depends on atu_pkg (degree threshold table)
`default_nettype none

module atu_deg_cell #(
  parameter int BIT = 0
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  atu_pkg::deg_t  in_data,
  output logic           out_valid,
  output atu_pkg::deg_t  out_data
);
  import atu_pkg::*;

  logic [DEG_BITS-1:0] cand;
  deg_t                data_next;

  always_comb begin
    cand      = in_data.deg | (DEG_BITS'(1) << BIT);
    data_next = in_data;
    if (in_data.a36 >= DEG_THR[cand]) data_next.deg = cand;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

/* rtl/accel_tilt_angle_unit.sv */
// accel_tilt_angle_unit: pipelined tilt angle from one three-axis sample
// depends on atu_pkg, atu_sqrt_cell, atu_cordic_cell, atu_div_cell, atu_deg_cell
//
// usage
//   input transaction: cmd and accel_x/y/z are taken at a rising edge where
//   start is high and busy is low. busy is high only while rst is high, so
//   one transaction can be taken at every clock edge
//   output transaction: done is high for exactly one cycle with angle_deg
//   valid in that same cycle; the receiver cannot hold it off
//   cmd 0 is the angle against z, 1 the x tilt, 2 the y tilt, 3 gives zero
// throughput and pipeline
//   one transaction per cycle, sustained
//   done follows the accepting edge through every cell chain: 56 square
//   root cells, ARCTAN_STAGES cordic cells, 62 divider cells, 7 degree
//   cells, plus the capture, square, sum, setup and output registers
// reset
//   rst clears every valid bit; transactions in flight are dropped
`default_nettype none

module accel_tilt_angle_unit #(
  parameter int ARCTAN_STAGES = 24
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire        [1:0]  cmd,
  input  wire signed [15:0] accel_x,
  input  wire signed [15:0] accel_y,
  input  wire signed [15:0] accel_z,
  output logic              done,
  output logic signed [7:0] angle_deg
);
  import atu_pkg::*;

  // the pipeline never stalls, so only reset holds off a transaction
  assign busy = rst;

  logic accept;
  assign accept = start & ~busy;

  // ---------------- capture: magnitudes and operand routing ----------------
  logic [15:0] ax, ay, az;
  logic [15:0] sel_a, sel_b;
  sq_meta_t    sel_meta;

  always_comb begin
    ax = accel_x[15] ? 16'(-accel_x) : 16'(accel_x);
    ay = accel_y[15] ? 16'(-accel_y) : 16'(accel_y);
    az = accel_z[15] ? 16'(-accel_z) : 16'(accel_z);
    sel_meta.cmd = cmd;
    case (cmd_e'(cmd))
      CMD_VS_Z: begin
        sel_a = ax; sel_b = ay; sel_meta.other = az; sel_meta.neg = accel_z[15];
      end
      CMD_X: begin
        sel_a = ay; sel_b = az; sel_meta.other = ax; sel_meta.neg = accel_x[15];
      end
      CMD_Y: begin
        sel_a = ax; sel_b = az; sel_meta.other = ay; sel_meta.neg = accel_y[15];
      end
      default: begin
        sel_a = '0; sel_b = '0; sel_meta.other = '0; sel_meta.neg = 1'b0;
      end
    endcase
  end

  logic        v1, v2, v3;
  logic [15:0] a1, b1;
  logic [31:0] p1, p2, s3;
  sq_meta_t    m1, m2, m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= sel_a;
    b1 <= sel_b;
    m1 <= sel_meta;
    // squares, one multiplier each
    p1 <= a1 * a1;
    p2 <= b1 * b1;
    m2 <= m1;
    // sum of squares stays below 2^31 + 1
    s3 <= 32'(p1 + p2);
    m3 <= m2;
  end

  // ---------------- square root chain ----------------
  logic sq_v [0:SQRT_ITERS];
  sq_t  sq_d [0:SQRT_ITERS];

  assign sq_v[0]      = v3;
  assign sq_d[0].rem  = '0;
  assign sq_d[0].root = '0;
  assign sq_d[0].s    = s3;
  assign sq_d[0].meta = m3;

  for (genvar g = 0; g < SQRT_ITERS; g++) begin : g_sqrt
    atu_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[g]),
      .in_data   (sq_d[g]),
      .out_valid (sq_v[g+1]),
      .out_data  (sq_d[g+1])
    );
  end

  // ---------------- numerator / denominator and special cases ----------------
  sq_t         sq_last;
  logic [55:0] root;
  logic [55:0] other_fx;
  logic [55:0] num, den;
  res_meta_t   post_meta;

  always_comb begin
    sq_last  = sq_d[SQRT_ITERS];
    root     = sq_last.root;
    other_fx = {sq_last.meta.other, 40'b0};
    if (cmd_e'(sq_last.meta.cmd) == CMD_VS_Z) begin
      num = root;
      den = other_fx;
    end else begin
      num = other_fx;
      den = root;
    end
    post_meta.neg = sq_last.meta.neg;
    // selector three and a zero numerator give zero, a zero denominator 90
    if (cmd_e'(sq_last.meta.cmd) == CMD_ZERO || num == '0) begin
      post_meta.fixed   = 1'b1;
      post_meta.deg_fix = '0;
    end else if (den == '0) begin
      post_meta.fixed   = 1'b1;
      post_meta.deg_fix = DEG_MAX;
    end else begin
      post_meta.fixed   = 1'b0;
      post_meta.deg_fix = '0;
    end
  end

  logic  cd_v [0:ARCTAN_STAGES];
  cord_t cd_d [0:ARCTAN_STAGES];

  always_ff @(posedge clk) begin
    if (rst) cd_v[0] <= 1'b0;
    else     cd_v[0] <= sq_v[SQRT_ITERS];
  end

  always_ff @(posedge clk) begin
    cd_d[0].cx   <= signed'({8'b0, den});
    cd_d[0].cy   <= signed'({8'b0, num});
    cd_d[0].acc  <= '0;
    cd_d[0].meta <= post_meta;
  end

  // ---------------- cordic vectoring chain ----------------
  for (genvar g = 0; g < ARCTAN_STAGES; g++) begin : g_cordic
    atu_cordic_cell #(.STAGE(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cd_v[g]),
      .in_data   (cd_d[g]),
      .out_valid (cd_v[g+1]),
      .out_data  (cd_d[g+1])
    );
  end

  // ---------------- residual division setup ----------------
  cord_t cd_last;
  assign cd_last = cd_d[ARCTAN_STAGES];

  logic dv_v [0:DIV_STEPS];
  div_t dv_d [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= cd_v[ARCTAN_STAGES];
  end

  always_ff @(posedge clk) begin
    dv_d[0].r      <= cd_last.cy[63] ? 64'(-cd_last.cy) : 64'(cd_last.cy);
    dv_d[0].bx     <= cd_last.cx;
    dv_d[0].q      <= '0;
    dv_d[0].acc    <= cd_last.acc;
    dv_d[0].cy_neg <= cd_last.cy[63];
    // a non-positive x after rotation gives a zero angle
    dv_d[0].zero   <= (cd_last.cx <= 0);
    dv_d[0].meta   <= cd_last.meta;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    atu_div_cell #(.STEP(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_v[g]),
      .in_data   (dv_d[g]),
      .out_valid (dv_v[g+1]),
      .out_data  (dv_d[g+1])
    );
  end

  // ---------------- residual term and angle to Q36 ----------------
  div_t               dv_last;
  logic [63:0]        q_ext;
  logic signed [63:0] acc_f;
  logic [63:0]        atan_q60;

  always_comb begin
    dv_last = dv_d[DIV_STEPS];
    q_ext   = {2'b00, dv_last.q};
    acc_f   = dv_last.cy_neg ? (dv_last.acc - signed'(q_ext))
                             : (dv_last.acc + signed'(q_ext));
    atan_q60 = (dv_last.zero || acc_f[63]) ? '0 : acc_f;
  end

  logic dg_v [0:DEG_BITS];
  deg_t dg_d [0:DEG_BITS];

  always_ff @(posedge clk) begin
    if (rst) dg_v[0] <= 1'b0;
    else     dg_v[0] <= dv_v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    dg_d[0].a36  <= atan_q60[63:24];
    dg_d[0].deg  <= '0;
    dg_d[0].meta <= dv_last.meta;
  end

  // ---------------- degree bisection chain ----------------
  for (genvar g = 0; g < DEG_BITS; g++) begin : g_deg
    atu_deg_cell #(.BIT(DEG_BITS - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dg_v[g]),
      .in_data   (dg_d[g]),
      .out_valid (dg_v[g+1]),
      .out_data  (dg_d[g+1])
    );
  end

  // ---------------- sign and output register ----------------
  deg_t                dg_last;
  logic [DEG_BITS-1:0] deg_mag;
  logic [7:0]          angle_next;

  always_comb begin
    dg_last    = dg_d[DEG_BITS];
    deg_mag    = dg_last.meta.fixed ? dg_last.meta.deg_fix : dg_last.deg;
    angle_next = dg_last.meta.neg ? 8'(-{1'b0, deg_mag}) : {1'b0, deg_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dg_v[DEG_BITS];
  end

  always_ff @(posedge clk) begin
    angle_deg <= signed'(angle_next);
  end

endmodule

`default_nettype wire

/* rtl/atu_checker.sv */
// atu_checker: port-level assertions for accel_tilt_angle_unit, and its bind
// depends on atu_pkg (selector codes) and the top level's ports
`default_nettype none

module atu_checker #(
  parameter int ARCTAN_STAGES = 24
) (
  input wire              clk,
  input wire              rst,
  input wire              start,
  input wire              busy,
  input wire        [1:0] cmd,
  input wire signed [15:0] accel_x,
  input wire signed [15:0] accel_y,
  input wire signed [15:0] accel_z,
  input wire              done,
  input wire signed [7:0] angle_deg
);
  import atu_pkg::*;

  localparam int LAT = 132 + ARCTAN_STAGES;

  logic acc_t;
  assign acc_t = start & ~busy;

  // every result is in the legal angle range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_deg >= -8'sd90 && angle_deg <= 8'sd90))
    else $error("angle out of range");

  // a result only follows a transaction taken a fixed latency earlier
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc_t, LAT))
    else $error("result without a transaction");

  // every transaction yields its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc_t |-> ##LAT done)
    else $error("result missing");

  // selector three and an all-zero sample give zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (acc_t && (cmd == CMD_ZERO ||
               (accel_x == 16'sd0 && accel_y == 16'sd0 && accel_z == 16'sd0)))
    |-> ##LAT (angle_deg == 8'sd0))
    else $error("zero case gave nonzero angle");

endmodule

bind accel_tilt_angle_unit atu_checker #(.ARCTAN_STAGES(ARCTAN_STAGES)) u_atu_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cmd       (cmd),
  .accel_x   (accel_x),
  .accel_y   (accel_y),
  .accel_z   (accel_z),
  .done      (done),
  .angle_deg (angle_deg)
);

`default_nettype wire

/* bench/testbench.sv */
// testbench for accel_tilt_angle_unit: directed and random samples, each checked
// against a bit-exact fixed-point tilt predictor; depends on atu_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import atu_pkg::*;

  localparam int STAGES   = 24;
  localparam int WATCHDOG = 4000;    // cycles with no transaction or result before giving up
  localparam int DRAIN    = 300;     // covers the pipeline latency

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic        [1:0] cmd = '0;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic              done;
  logic signed [7:0] angle_deg;

  accel_tilt_angle_unit #(.ARCTAN_STAGES(STAGES)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .done(done), .angle_deg(angle_deg)
  );

  always #6 clk = ~clk;

  longint unsigned   rot_angle [0:31];   // q60 radians per cordic stage
  logic signed [7:0] angle_queue [$];    // expected angles, oldest first
  int                fail_count = 0;
  int                idle_pct = 0;
  int                sent = 0;
  int                checked = 0;
  int                quiet = 0;
  int                cmd_seen [4] = '{0, 0, 0, 0};

  // atan(1/n) in q60 by its alternating series
  function automatic longint unsigned arctan_inv(longint unsigned n);
    longint unsigned p, sum, sq, t, k;
    p   = (64'd1 << 60) / n;
    sum = p;
    sq  = n * n;
    k   = 1;
    while (p != 0) begin
      p = p / sq;
      t = p / (2 * k + 1);
      if (k[0]) sum = sum - t;
      else      sum = sum + t;
      k++;
    end
    return sum;
  endfunction

  // floor(sqrt(s) * 2^40), one root bit per step
  function automatic longint unsigned root_q40(longint unsigned s);
    longint unsigned rem, root, pair, trial;
    rem  = 0;
    root = 0;
    for (int i = 0; i < 16 + FRAC_SQRT; i++) begin
      pair  = (i < 16) ? ((s >> (2 * (15 - i))) & 64'd3) : 64'd0;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // atan(num/den) in q60: cordic vectoring then a linear residual term
  function automatic longint unsigned vector_angle(longint unsigned num,
                                                   longint unsigned den);
    longint cx, cy, acc, dx, dy;
    longint unsigned ay, bx, qi, r, frac, q;
    cx  = longint'(den);
    cy  = longint'(num);
    acc = 0;
    frac = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += longint'(rot_angle[i]);
      end else begin
        cx -= dx; cy += dy; acc -= longint'(rot_angle[i]);
      end
    end
    if (cx <= 0) return 0;
    bx = longint'(cx);
    ay = (cy < 0) ? longint'(-cy) : longint'(cy);
    qi = ay / bx;
    r  = ay % bx;
    for (int i = 0; i < 60; i++) begin
      r    = r << 1;
      frac = frac << 1;
      if (r >= bx) begin
        r    = r - bx;
        frac = frac | 64'd1;
      end
    end
    if (qi > 3) qi = 3;
    q = (qi << 60) + frac;
    if (cy < 0) acc -= longint'(q);
    else        acc += longint'(q);
    if (acc < 0) return 0;
    return longint'(acc);
  endfunction

  function automatic logic signed [7:0] tilt_angle(cmd_e c, logic signed [15:0] x,
                                                   logic signed [15:0] y,
                                                   logic signed [15:0] z);
    longint unsigned ax, ay, az, num, den, a36, deg;
    logic num_neg, den_neg;
    longint res;
    ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
    ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
    az = (z < 0) ? longint'(-longint'(z)) : longint'(z);
    num = 0; den = 0; num_neg = 1'b0; den_neg = 1'b0; res = 0;
    case (c)
      CMD_VS_Z: begin
        num = root_q40(ax * ax + ay * ay);
        den = az << FRAC_SQRT;
        den_neg = z < 0;
      end
      CMD_X: begin
        num = ax << FRAC_SQRT;
        num_neg = x < 0;
        den = root_q40(ay * ay + az * az);
      end
      CMD_Y: begin
        num = ay << FRAC_SQRT;
        num_neg = y < 0;
        den = root_q40(ax * ax + az * az);
      end
      default: ;
    endcase
    if (c != CMD_ZERO && num != 0) begin
      if (den == 0) begin
        deg = 90;
      end else begin
        a36 = vector_angle(num, den) >> 24;
        deg = (a36 * 64'd18000000) / (64'd314159 << 36);
        if (deg > 90) deg = 90;
      end
      res = longint'(deg);
      if (num_neg != den_neg) res = -res;
    end
    return res[7:0];
  endfunction

  // input monitor: predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      angle_queue.push_back(tilt_angle(cmd_e'(cmd), accel_x, accel_y, accel_z));
      cmd_seen[cmd]++;
      sent++;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (done) begin
      if (angle_queue.size() == 0) begin
        $error("angle_deg: unexpected result %0d", angle_deg);
        fail_count++;
      end else begin
        if (angle_deg !== angle_queue[0]) begin
          $error("angle_deg: expected %0d, actual %0d", angle_queue[0], angle_deg);
          fail_count++;
        end
        void'(angle_queue.pop_front());
        checked++;
      end
    end
    if (done || (start && !busy)) quiet = 0;
    else                          quiet++;
    if (quiet >= WATCHDOG) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("accel_tilt_angle_unit verification failed");
      $finish;
    end
  end

  // one input transaction; each cycle ahead of it idles with chance idle_pct
  task automatic send_sample(cmd_e c, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= c;
    accel_x <= x;
    accel_y <= y;
    accel_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
  endtask

  // axis value: extremes, small values, zero or fully random bits
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3, 4:    return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_axis_extremes();
    cmd_e c;
    for (int k = 0; k < 3; k++) begin
      c = cmd_e'(k);
      send_sample(c, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(c, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(c, 16'sh8000, 16'sh7fff, 16'sh8000);
    end
    send_sample(CMD_ZERO, 16'sh7fff, 16'sh8000, 16'sh1234);
    send_sample(CMD_ZERO, 16'sh8000, 16'sh7fff, 16'sh0000);
  endtask

  task automatic test_special_cases();
    // zero denominator gives +-90 by the numerator sign, and a zero y numerator gives 0
    send_sample(CMD_VS_Z, 16'sd300, -16'sd5, 16'sd0);
    send_sample(CMD_X, -16'sd1, 16'sd0, 16'sd0);
    send_sample(CMD_Y, 16'sd1, 16'sd0, 16'sd0);
    // zero over zero
    send_sample(CMD_VS_Z, 16'sd0, 16'sd0, 16'sd0);
    send_sample(CMD_X, 16'sd0, 16'sd0, 16'sd0);
    // zero numerator, with a negative z in the denominator term
    send_sample(CMD_VS_Z, 16'sd0, 16'sd0, -16'sd400);
    send_sample(CMD_Y, 16'sd77, 16'sd0, -16'sd9);
    // sign combinations at 45 degrees and a near-zero angle
    send_sample(CMD_VS_Z, 16'sd100, 16'sd0, -16'sd100);
    send_sample(CMD_X, -16'sd100, 16'sd0, 16'sd100);
    send_sample(CMD_Y, 16'sd1000, 16'sd1, 16'sd1);
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int n = 0; n < count; n++)
      send_sample(cmd_e'($urandom_range(3)), pick_axis(), pick_axis(), pick_axis());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 32; i++)
      rot_angle[i] = (i == 0) ? arctan_inv(2) + arctan_inv(3) : arctan_inv(64'd1 << i);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_axis_extremes();
    test_special_cases();
    wait_drained();          // let every pending transaction come out first
    test_random(460, 36);
    test_random(460, 65);
    test_random(460, 0);

    start <= 1'b0;
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d samples (cmd 0..3: %0d %0d %0d %0d), %0d angles checked",
             sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], checked);
    $display("sender gaps at 36%%, 65%% and none, plus a full drain mid-run");
    if (fail_count == 0 && angle_queue.size() == 0) begin
      $display("accel_tilt_angle_unit verification clean");
    end else begin
      $display("accel_tilt_angle_unit verification failed");
    end
    $finish;
  end

endmodule
